@@ design/rfou_pkg.sv @@
// ----------------------------------------------------------------------------
// rfou_pkg
// shared types and constants for the overwrite-oldest ring fifo with unget
// ----------------------------------------------------------------------------
`default_nettype none

package rfou_pkg;

	localparam int DepthDef = 256;
	localparam int DataW    = 64;
	localparam int ReqW     = 2;
	localparam int StatW    = 2;
	localparam int CountW   = 8;
	localparam int OutDataW = DataW + CountW;

	// request codes, the fourth code is ignored
	typedef enum logic [ReqW-1:0] {
		REQ_PUSH  = 2'd0,
		REQ_POP   = 2'd1,
		REQ_UNGET = 2'd2
	} req_t;

	typedef enum logic [StatW-1:0] {
		ST_OK          = 2'd0,
		ST_POP_EMPTY   = 2'd1,
		ST_PUSH_DROP   = 2'd2,
		ST_UNGET_FULL  = 2'd3
	} status_t;

	typedef enum logic {
		FSM_IDLE = 1'b0,
		FSM_EXEC = 1'b1
	} fsm_t;

	// controller to datapath
	typedef struct packed {
		logic exec;  // take the input item, update pointers and store
		logic load;  // move the finished result into the output register
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;  // output register empty or being taken
	} sts_t;

endpackage

`default_nettype wire

@@ design/rfou_ctrl.sv @@
// ----------------------------------------------------------------------------
// rfou_ctrl
// two-state sequencer: take an item, then hand its result to the output stage
// ----------------------------------------------------------------------------
`default_nettype none

module rfou_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           s_tvalid,
	output logic                s_tready,
	input  rfou_pkg::sts_t      sts,
	output rfou_pkg::cmd_t      cmd
);
	import rfou_pkg::*;

	fsm_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		cmd      = '0;
		case (state_q)
			FSM_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.exec = 1'b1;
					state_d  = FSM_EXEC;
				end
			end
			FSM_EXEC: begin
				// wait here while the previous result is still unclaimed
				if (sts.out_free) begin
					cmd.load = 1'b1;
					state_d  = FSM_IDLE;
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ design/rfou_dpath.sv @@
// ----------------------------------------------------------------------------
// rfou_dpath
// head and tail pointers, record memory and the registered output stage
// ----------------------------------------------------------------------------
`default_nettype none

module rfou_dpath #(
	parameter int DEPTH = rfou_pkg::DepthDef
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  rfou_pkg::cmd_t                     cmd,
	output rfou_pkg::sts_t                     sts,
	input  wire logic [rfou_pkg::DataW-1:0]    s_tdata,
	input  wire logic [rfou_pkg::ReqW-1:0]     s_tuser,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [rfou_pkg::OutDataW-1:0]      m_tdata,
	output logic [rfou_pkg::StatW-1:0]         m_tuser
);
	import rfou_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int XW = (PW + 1 > CountW) ? PW + 1 : CountW;
	localparam logic [PW-1:0] PtrMax = PW'(DEPTH - 1);

	logic [DataW-1:0] mem [DEPTH];

	logic [PW-1:0]    head_q, tail_q;
	logic [PW-1:0]    head_inc, tail_inc, tail_dec;
	logic             full, empty;
	req_t             req;

	logic             wr_en;
	logic [PW-1:0]    wr_addr;
	logic [PW-1:0]    head_d, tail_d;
	status_t          stat_d;
	logic             pop_ok_d;

	logic [DataW-1:0] rd_s1;
	status_t          stat_s1;
	logic             pop_ok_s1;

	logic [XW-1:0]    diff;
	logic             valid_q;
	logic [DataW-1:0] dout_q;
	logic [CountW-1:0] count_q;
	status_t          ustat_q;

	assign head_inc = (head_q == PtrMax) ? '0 : head_q + PW'(1);
	assign tail_inc = (tail_q == PtrMax) ? '0 : tail_q + PW'(1);
	assign tail_dec = (tail_q == '0) ? PtrMax : tail_q - PW'(1);
	assign full     = (head_inc == tail_q);
	assign empty    = (head_q == tail_q);
	assign req      = req_t'(s_tuser);

	always_comb begin
		wr_en    = 1'b0;
		wr_addr  = head_q;
		head_d   = head_q;
		tail_d   = tail_q;
		stat_d   = ST_OK;
		pop_ok_d = 1'b0;
		case (req)
			REQ_PUSH: begin
				wr_en  = 1'b1;
				head_d = head_inc;
				if (full) begin
					tail_d = tail_inc;
					stat_d = ST_PUSH_DROP;
				end
			end
			REQ_POP: begin
				if (empty) begin
					stat_d = ST_POP_EMPTY;
				end else begin
					pop_ok_d = 1'b1;
					tail_d   = tail_inc;
				end
			end
			REQ_UNGET: begin
				if (full) begin
					stat_d = ST_UNGET_FULL;
				end else begin
					wr_en   = 1'b1;
					wr_addr = tail_dec;
					tail_d  = tail_dec;
				end
			end
			default: begin
			end
		endcase
	end

	// record memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (cmd.exec && wr_en) begin
			mem[wr_addr] <= s_tdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			rd_s1     <= mem[tail_q];
			stat_s1   <= stat_d;
			pop_ok_s1 <= pop_ok_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
		end else if (cmd.exec) begin
			head_q <= head_d;
			tail_q <= tail_d;
		end
	end

	// held records from the updated pointers
	always_comb begin
		diff = XW'(head_q) - XW'(tail_q);
		if (head_q < tail_q) begin
			diff = diff + XW'(DEPTH);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dout_q  <= pop_ok_s1 ? rd_s1 : '0;
			count_q <= diff[CountW-1:0];
			ustat_q <= stat_s1;
		end
	end

	assign sts.out_free = !valid_q || m_tready;
	assign m_tvalid     = valid_q;
	assign m_tdata      = {count_q, dout_q};
	assign m_tuser      = ustat_q;

endmodule

`default_nettype wire

@@ design/ring_fifo_overwrite_unget_unit.sv @@
// ----------------------------------------------------------------------------
// ring_fifo_overwrite_unget_unit
// circular fifo of 64-bit records: push overwrites the oldest, pop, unget
// ----------------------------------------------------------------------------
// usage
//   slave channel takes one request per item: s_tuser holds the request kind
//   (push, pop, unget before tail), s_tdata the record for push and unget
//   master channel returns exactly one result item per request: m_tuser holds
//   the status, m_tdata the popped record and the count of held records
//   the fifo keeps one slot empty, so it holds at most DEPTH-1 records
// timing
//   an item is taken in the idle state; the pointer update and memory read are
//   registered at that edge, and in the exec state the result enters the output
//   register once it is free; a new item is taken only after the previous result
//   has moved to the output register, set by the idle and exec states of the
//   sequencer, the exec state covering the synchronous read of the record memory
// reset
//   arst_n clears head and tail to zero (fifo empty) and drops m_tvalid;
//   memory contents are not cleared and are never returned before being written
// stall
//   a waiting result does not block the next item from being taken; that item
//   then holds in the exec state until m_tready frees the output register
// ----------------------------------------------------------------------------
`default_nettype none

module ring_fifo_overwrite_unget_unit #(
	parameter int DEPTH = rfou_pkg::DepthDef
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [rfou_pkg::DataW-1:0]    s_tdata,   // data_in[63:0]
	input  wire logic [rfou_pkg::ReqW-1:0]     s_tuser,   // req_type[1:0]
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [rfou_pkg::OutDataW-1:0]      m_tdata,   // data_out[63:0], count[71:64]
	output logic [rfou_pkg::StatW-1:0]         m_tuser    // status[1:0]
);
	import rfou_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencer: idle takes an item, exec hands the result over
	rfou_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// pointers, record memory and output register
	rfou_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

`default_nettype wire

@@ tb/sv/tb_ring_fifo_overwrite_unget_unit.sv @@
// ----------------------------------------------------------------------------
// tb_ring_fifo_overwrite_unget_unit
// self-checking bench for the overwrite-oldest ring fifo with unget
// ----------------------------------------------------------------------------
// requests go in on the slave stream and each is mirrored in a local fifo
// model when its handshake completes; the model's answer is queued and every
// result item on the master stream is compared field by field with the oldest
// queued answer. directed items hit the corner cases, a fill pass walks the
// fifo to full and back, and biased random traffic runs under four idling
// mixes on both streams
// ----------------------------------------------------------------------------

module tb_ring_fifo_overwrite_unget_unit;

	timeunit 1ns;
	timeprecision 1ps;

	import rfou_pkg::*;

	localparam int FIFO_DEPTH = DepthDef;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 10;
	localparam int MAX_REPORTS = 40;
	localparam int RESET_CYCLES = 8;
	localparam int SEGMENT_ITEMS = 25;
	localparam int PHASE_ITEMS = 50;
	localparam logic [ReqW-1:0] REQ_SPARE = 2'd3; // unused code, must be ignored
	localparam logic [DataW-1:0] ALL_ONES = {DataW{1'b1}};
	localparam logic [DataW-1:0] CHECKER_A = {(DataW/2){2'b01}};
	localparam logic [DataW-1:0] CHECKER_B = {(DataW/2){2'b10}};

	// traffic bias for a random segment
	typedef enum int {
		MIX_FILL,
		MIX_DRAIN,
		MIX_EVEN
	} mix_t;

	typedef struct {
		status_t                stat;
		logic [DataW-1:0]       rec;
		logic [CountW-1:0]      cnt;
	} fifo_result_t;

	logic                       clk;
	logic                       arst_n;
	logic                       s_tvalid;
	logic                       s_tready;
	logic [DataW-1:0]           s_tdata;   // data_in[63:0]
	logic [ReqW-1:0]            s_tuser;   // req_type[1:0]
	logic                       m_tvalid;
	logic                       m_tready = 1'b0;
	logic [OutDataW-1:0]        m_tdata;   // data_out[63:0], count[71:64]
	logic [StatW-1:0]           m_tuser;   // status[1:0]

	// local copy of the fifo
	logic [DataW-1:0]           rec_mem [FIFO_DEPTH];
	int                         head_idx = 0;
	int                         tail_idx = 0;

	// answers waiting for their result item
	fifo_result_t               pending_results [$];

	int                         idle_pct = 0;   // sender gap chance, percent
	int                         stall_pct = 0;  // receiver stall chance, percent
	int                         cycle_cnt = 0;
	int                         error_cnt = 0;
	int                         checked_cnt = 0;
	int                         kind_hits [4] = '{default: 0};
	int                         stat_hits [4] = '{default: 0};

	ring_fifo_overwrite_unget_unit #(
		.DEPTH(FIFO_DEPTH)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	// 2 ns clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// watchdog, a hang shows up here
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_cnt, pending_results.size());
			$display("tb_ring_fifo_overwrite_unget_unit: FAIL");
			$finish;
		end
	end

	// receiver back-pressure, changed on the falling edge only
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	// one line per mismatch, the print is capped so a dead design stays readable
	task automatic report_mismatch(input string what);
		error_cnt++;
		if (error_cnt <= MAX_REPORTS)
			$display("mismatch at cycle %0d: %s", cycle_cnt, what);
	endtask

	// result checker: sampled at the rising edge, before the design updates
	always @(posedge clk) begin : result_check
		fifo_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result item with no request outstanding, tuser %0d",
					m_tuser));
			end else begin
				want = pending_results.pop_front();
				checked_cnt++;
				if (m_tuser !== want.stat)
					report_mismatch($sformatf("status got %0d want %0d",
						m_tuser, want.stat));
				if (m_tdata[DataW-1:0] !== want.rec)
					report_mismatch($sformatf("record got %h want %h",
						m_tdata[DataW-1:0], want.rec));
				if (m_tdata[OutDataW-1:DataW] !== want.cnt)
					report_mismatch($sformatf("count got %0d want %0d",
						m_tdata[OutDataW-1:DataW], want.cnt));
			end
		end
	end

	// records held in the local copy
	function automatic int fifo_level();
		return (head_idx - tail_idx + FIFO_DEPTH) % FIFO_DEPTH;
	endfunction

	// apply one accepted request to the local copy and queue its answer
	task automatic fifo_predict(input logic [ReqW-1:0] kind, input logic [DataW-1:0] rec);
		fifo_result_t res;
		int nxt;
		res.stat = ST_OK;
		res.rec = '0;
		nxt = (head_idx + 1) % FIFO_DEPTH;
		case (kind)
			REQ_PUSH: begin
				// full: the oldest record goes to make room
				if (nxt == tail_idx) begin
					tail_idx = (tail_idx + 1) % FIFO_DEPTH;
					res.stat = ST_PUSH_DROP;
				end
				rec_mem[head_idx] = rec;
				head_idx = nxt;
			end
			REQ_POP: begin
				if (head_idx == tail_idx) begin
					res.stat = ST_POP_EMPTY;
				end else begin
					res.rec = rec_mem[tail_idx];
					tail_idx = (tail_idx + 1) % FIFO_DEPTH;
				end
			end
			REQ_UNGET: begin
				// refused when full, it would make head meet tail
				if (nxt == tail_idx) begin
					res.stat = ST_UNGET_FULL;
				end else begin
					tail_idx = (tail_idx + FIFO_DEPTH - 1) % FIFO_DEPTH;
					rec_mem[tail_idx] = rec;
				end
			end
			default: ;
		endcase
		res.cnt = CountW'(fifo_level());
		pending_results.push_back(res);
		kind_hits[kind]++;
		stat_hits[res.stat]++;
	endtask

	// drive one request item; entered and left at a falling edge
	task automatic send_req(input logic [ReqW-1:0] kind, input logic [DataW-1:0] rec);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= rec;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		fifo_predict(kind, rec);
		@(negedge clk);
	endtask

	function automatic logic [DataW-1:0] random_record();
		return {$urandom, $urandom};
	endfunction

	// corner cases on an empty or nearly empty fifo, no idling
	task automatic test_directed();
		idle_pct = 0;
		stall_pct = 0;
		send_req(REQ_POP, ALL_ONES);        // pop on empty straight after reset
		send_req(REQ_PUSH, ALL_ONES);
		send_req(REQ_PUSH, '0);
		send_req(REQ_POP, '0);
		send_req(REQ_POP, ALL_ONES);
		send_req(REQ_POP, '0);              // empty again
		send_req(REQ_UNGET, CHECKER_A);     // unget into an empty fifo
		send_req(REQ_POP, '0);
		send_req(REQ_SPARE, ALL_ONES);      // unknown request, ignored
		send_req(REQ_PUSH, CHECKER_B);
		send_req(REQ_UNGET, CHECKER_A);     // goes in front of the pushed record
		send_req(REQ_SPARE, CHECKER_B);
		send_req(REQ_POP, '0);
		send_req(REQ_POP, '0);
		send_req(REQ_POP, '0);
		send_req(REQ_UNGET, ALL_ONES);
		send_req(REQ_UNGET, '0);
		send_req(REQ_POP, ALL_ONES);
		send_req(REQ_POP, ALL_ONES);
		send_req(REQ_SPARE, '0);
	endtask

	// fill to the limit, overwrite, refused and accepted unget, then drain
	task automatic test_full_and_wrap();
		idle_pct = 0;
		stall_pct = 49;
		while (fifo_level() < FIFO_DEPTH - 1)
			send_req(REQ_PUSH, random_record());
		idle_pct = 30;
		stall_pct = 30;
		repeat (3)
			send_req(REQ_PUSH, random_record());  // each drops the oldest
		send_req(REQ_UNGET, ALL_ONES);            // refused on full
		send_req(REQ_SPARE, random_record());
		send_req(REQ_POP, '0);
		send_req(REQ_UNGET, CHECKER_B);           // room again, accepted
		send_req(REQ_UNGET, CHECKER_A);           // full once more, refused
		idle_pct = 49;
		stall_pct = 0;
		while (fifo_level() > 0)
			send_req(REQ_POP, random_record());
		send_req(REQ_POP, random_record());
	endtask

	function automatic logic [ReqW-1:0] pick_kind(input mix_t mix);
		int r;
		r = $urandom_range(99);
		case (mix)
			MIX_FILL:  return (r < 70) ? REQ_PUSH : (r < 82) ? REQ_POP :
				(r < 95) ? REQ_UNGET : REQ_SPARE;
			MIX_DRAIN: return (r < 15) ? REQ_PUSH : (r < 80) ? REQ_POP :
				(r < 95) ? REQ_UNGET : REQ_SPARE;
			default:   return (r < 40) ? REQ_PUSH : (r < 75) ? REQ_POP :
				(r < 95) ? REQ_UNGET : REQ_SPARE;
		endcase
	endfunction

	// biased random traffic under the four idling mixes
	task automatic test_random_traffic();
		int idle_mix [4] = '{0, 49, 0, 30};
		int stall_mix [4] = '{0, 0, 49, 30};
		mix_t mix;
		for (int phase = 0; phase < 4; phase++) begin
			idle_pct = idle_mix[phase];
			stall_pct = stall_mix[phase];
			// one phase starts close to full so overwrite and refusal recur
			if (phase == 2) begin
				while (fifo_level() < FIFO_DEPTH - 4)
					send_req(REQ_PUSH, random_record());
			end
			for (int seg = 0; seg < PHASE_ITEMS / SEGMENT_ITEMS; seg++) begin
				mix = mix_t'($urandom_range(2));
				if (phase == 2 && seg < 3)
					mix = MIX_EVEN;
				repeat (SEGMENT_ITEMS)
					send_req(pick_kind(mix), random_record());
			end
		end
	endtask

	initial begin
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = REQ_PUSH;
		arst_n = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();
		test_full_and_wrap();
		test_random_traffic();

		// stream done, let every result drain out
		s_tvalid <= 1'b0;
		stall_pct = 0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("requests: %0d push, %0d pop, %0d unget, %0d unknown; %0d results checked",
			kind_hits[REQ_PUSH], kind_hits[REQ_POP], kind_hits[REQ_UNGET],
			kind_hits[REQ_SPARE], checked_cnt);
		$display("outcomes: %0d ok, %0d empty pops, %0d overwrites, %0d refused ungets",
			stat_hits[ST_OK], stat_hits[ST_POP_EMPTY], stat_hits[ST_PUSH_DROP],
			stat_hits[ST_UNGET_FULL]);
		if (error_cnt == 0) begin
			$display("tb_ring_fifo_overwrite_unget_unit: PASS");
		end else begin
			$display("%0d mismatches", error_cnt);
			$display("tb_ring_fifo_overwrite_unget_unit: FAIL");
		end
		$finish;
	end

endmodule
